// File: hw/rtl/pwm_frequency_sweep_calc_unit_macros.svh
// Assertion macros shared by the PWM frequency sweep calculator RTL.
// Stand-alone header; the files that assert include it by name.
`ifndef PWM_FREQUENCY_SWEEP_CALC_UNIT_MACROS_SVH
`define PWM_FREQUENCY_SWEEP_CALC_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFSC_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFSC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/pfsc_pkg.sv
// Package of the PWM frequency sweep calculator: field widths, reset values,
// register indexes and constants. No dependencies.
package pfsc_pkg;

	localparam int CNT_W     = 16;              // timer counter and result width
	localparam int CLK_W     = 27;
	localparam int DUTY_W    = 7;
	localparam int STEP_W    = 20;
	localparam int FREQ_W    = 23;
	localparam int RPT_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int DIVD_W    = CLK_W + DUTY_W;  // widest dividend, duty times clock
	localparam int DIV2_W    = FREQ_W + 7;      // 100 times frequency
	localparam int RPT_DIV_W = 10;              // width of the report divisor
	localparam int ITER_W    = $clog2(DIVD_W + 1);

	localparam logic [CLK_W-1:0]     CLOCK_RESET    = CLK_W'(16000000);
	localparam logic [DUTY_W-1:0]    DUTY_RESET     = DUTY_W'(50);
	localparam logic [STEP_W-1:0]    STEP_RESET     = STEP_W'(1000);
	localparam logic [FREQ_W-1:0]    LIMIT_RESET    = FREQ_W'(4000000);
	localparam logic [FREQ_W-1:0]    RESTART_RESET  = FREQ_W'(10000);
	localparam logic [FREQ_W-1:0]    FREQ_RESET     = FREQ_W'(160000);
	localparam logic [FREQ_W-1:0]    FREQ_MAX       = '1;
	localparam logic [RPT_DIV_W-1:0] REPORT_DIVISOR = RPT_DIV_W'(1000);
	localparam logic [DIV2_W-1:0]    PERCENT_SCALE  = DIV2_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOCK   = 3'd0,
		CFG_DUTY    = 3'd1,
		CFG_STEP    = 3'd2,
		CFG_LIMIT   = 3'd3,
		CFG_RESTART = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		ACT_SWEEP = 1'b0,
		ACT_SET   = 1'b1
	} action_t;

endpackage

// File: hw/rtl/pfsc_cmd_if.sv
// Command channel of the PWM frequency sweep calculator: valid/ready with
// the action and target frequency. Depends on pfsc_pkg.
interface pfsc_cmd_if;
	import pfsc_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [FREQ_W-1:0] target_hz;

	modport source (output valid, output action, output target_hz, input ready);
	modport sink (input valid, input action, input target_hz, output ready);
endinterface

// File: hw/rtl/pfsc_res_if.sv
// Result channel of the PWM frequency sweep calculator: valid/ready with
// reload, compare, report and saturation fields. Depends on pfsc_pkg.
interface pfsc_res_if;
	import pfsc_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] reload_value;
	logic [CNT_W-1:0] compare_value;
	logic [RPT_W-1:0] report_byte;
	logic             report_valid;
	logic             saturated;

	modport source (output valid, output reload_value, output compare_value,
		output report_byte, output report_valid, output saturated, input ready);
	modport sink (input valid, input reload_value, input compare_value,
		input report_byte, input report_valid, input saturated, output ready);
endinterface

// File: hw/rtl/pwm_frequency_sweep_calc_unit.sv
// PWM frequency sweep calculator, top level.
// Depends on pfsc_pkg, pfsc_cmd_if, pfsc_res_if and the assertion macro header.
//
// Usage:
//   The cmd channel carries one command per transfer: action 0 is a sweep
//   tick that steps the stored frequency (or restarts it at the limit), action
//   1 is a direct set from target_hz that leaves the stored frequency alone.
//   Every command gives exactly one transfer on the res channel with the timer
//   reload value, compare value, a report byte and a saturation flag.
//   The configuration port writes one register per cycle with cfg_we high;
//   the user must write registers only while no command is in flight; the
//   block itself does not enforce this. Operation: three restoring dividers
//   (clock / f, duty * clock / (100 * f) and f / 1000) run side by side, one
//   quotient bit per cycle. After the setup step, the 34-step division loop
//   and the finish step, a result is loaded into the output register, and
//   cmd.ready rises at that same edge.
//   The output register separates the two sides: a new command is accepted
//   while a result still waits. If the receiver stalls, the next result waits
//   in the finish step until the output register is free.
//   Reset loads the register reset values and a stored frequency of 160000,
//   and leaves both channels idle.
`include "pwm_frequency_sweep_calc_unit_macros.svh"

module pwm_frequency_sweep_calc_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pfsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfsc_pkg::CLK_W-1:0]     cfg_data,
	pfsc_cmd_if.sink                       cmd,
	pfsc_res_if.source                     res
);
	import pfsc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CLK_W-1:0]  clk_hz_q;
	logic [DUTY_W-1:0] duty_q;
	logic [STEP_W-1:0] step_q;
	logic [FREQ_W-1:0] limit_q;
	logic [FREQ_W-1:0] restart_q;
	logic [FREQ_W-1:0] sweep_q;
	logic [ITER_W-1:0] cnt_q;
	logic              res_valid_q;

	logic [FREQ_W-1:0] freq_q;
	logic              tick_q;
	logic [DIV2_W-1:0] d2_q;
	logic [DIVD_W-1:0] n1_q, n2_q, n3_q;
	logic [FREQ_W-1:0]    r1_q;
	logic [DIV2_W-1:0]    r2_q;
	logic [RPT_DIV_W-1:0] r3_q;
	logic [CNT_W:0]       q1_q;
	logic [CNT_W-1:0]     q2_q;
	logic [RPT_W-1:0]     q3_q;
	logic                 o1_q, o2_q;

	logic [CNT_W-1:0] reload_q, compare_q;
	logic [RPT_W-1:0] report_q;
	logic             rvalid_q, sat_q;

	logic              accept;
	logic              out_load;
	logic [FREQ_W:0]   sweep_sum;
	logic [FREQ_W-1:0] sweep_next;

	logic [FREQ_W:0]    t1;
	logic [DIV2_W:0]    t2;
	logic [RPT_DIV_W:0] t3;
	logic               ge1, ge2, ge3;
	logic [FREQ_W:0]    s1;
	logic [DIV2_W:0]    s2;
	logic [RPT_DIV_W:0] s3;

	logic [CNT_W:0]   q1_dec;
	logic             reload_sat;
	logic [CNT_W-1:0] reload_fin;
	logic [CNT_W-1:0] compare_fin;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_FINISH) && (!res_valid_q || res.ready);

	// Sweep step: add while below the limit, clamp at the field maximum; else restart.
	assign sweep_sum  = {1'b0, sweep_q} + (FREQ_W + 1)'(step_q);
	always_comb begin
		if (sweep_q < limit_q) begin
			sweep_next = (sweep_sum > {1'b0, FREQ_MAX}) ? FREQ_MAX : sweep_sum[FREQ_W-1:0];
		end else begin
			sweep_next = restart_q;
		end
	end

	// One restoring division step per cycle in each of the three dividers.
	// A zero divisor yields an all-ones quotient, which saturates both values.
	assign t1  = {r1_q, n1_q[DIVD_W-1]};
	assign t2  = {r2_q, n2_q[DIVD_W-1]};
	assign t3  = {r3_q, n3_q[DIVD_W-1]};
	assign ge1 = (t1 >= {1'b0, freq_q});
	assign ge2 = (t2 >= {1'b0, d2_q});
	assign ge3 = (t3 >= {1'b0, REPORT_DIVISOR});
	assign s1  = ge1 ? (t1 - {1'b0, freq_q}) : t1;
	assign s2  = ge2 ? (t2 - {1'b0, d2_q}) : t2;
	assign s3  = ge3 ? (t3 - {1'b0, REPORT_DIVISOR}) : t3;

	// Reload is the quotient minus one, saturated when the quotient passes 2^CNT_W.
	assign q1_dec      = q1_q - (CNT_W + 1)'(1);
	assign reload_sat  = o1_q || (q1_q[CNT_W] && (q1_q[CNT_W-1:0] != '0));
	assign reload_fin  = reload_sat ? '1 :
		((q1_q == '0) ? '0 : q1_dec[CNT_W-1:0]);
	assign compare_fin = o2_q ? '1 : q2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			sweep_q     <= FREQ_RESET;
			clk_hz_q    <= CLOCK_RESET;
			duty_q      <= DUTY_RESET;
			step_q      <= STEP_RESET;
			limit_q     <= LIMIT_RESET;
			restart_q   <= RESTART_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CLOCK:   clk_hz_q  <= cfg_data;
					CFG_DUTY:    duty_q    <= cfg_data[DUTY_W-1:0];
					CFG_STEP:    step_q    <= cfg_data[STEP_W-1:0];
					CFG_LIMIT:   limit_q   <= cfg_data[FREQ_W-1:0];
					CFG_RESTART: restart_q <= cfg_data[FREQ_W-1:0];
					default: ;
				endcase
			end

			// A new result may replace the one leaving in the same cycle.
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action_t'(cmd.action) == ACT_SWEEP) begin
							sweep_q <= sweep_next;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q   <= ITER_W'(DIVD_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - ITER_W'(1);
					if (cnt_q == ITER_W'(1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tick_q <= (action_t'(cmd.action) == ACT_SWEEP);
					freq_q <= (action_t'(cmd.action) == ACT_SWEEP) ? sweep_next : cmd.target_hz;
				end
			end
			ST_SETUP: begin
				n1_q <= DIVD_W'(clk_hz_q);
				n2_q <= DIVD_W'(duty_q) * DIVD_W'(clk_hz_q);
				n3_q <= DIVD_W'(freq_q);
				d2_q <= DIV2_W'(freq_q) * PERCENT_SCALE;
				r1_q <= '0;
				r2_q <= '0;
				r3_q <= '0;
				q1_q <= '0;
				q2_q <= '0;
				q3_q <= '0;
				o1_q <= 1'b0;
				o2_q <= 1'b0;
			end
			ST_DIV: begin
				n1_q <= {n1_q[DIVD_W-2:0], 1'b0};
				n2_q <= {n2_q[DIVD_W-2:0], 1'b0};
				n3_q <= {n3_q[DIVD_W-2:0], 1'b0};
				r1_q <= s1[FREQ_W-1:0];
				r2_q <= s2[DIV2_W-1:0];
				r3_q <= s3[RPT_DIV_W-1:0];
				// Bits shifted out of the top set the sticky overflow flags.
				o1_q <= o1_q | q1_q[CNT_W];
				o2_q <= o2_q | q2_q[CNT_W-1];
				q1_q <= {q1_q[CNT_W-1:0], ge1};
				q2_q <= {q2_q[CNT_W-2:0], ge2};
				q3_q <= {q3_q[RPT_W-2:0], ge3};
			end
			ST_FINISH: begin
				if (out_load) begin
					reload_q  <= reload_fin;
					compare_q <= compare_fin;
					report_q  <= tick_q ? q3_q : '0;
					rvalid_q  <= tick_q;
					sat_q     <= reload_sat || o2_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid         = res_valid_q;
	assign res.reload_value  = reload_q;
	assign res.compare_value = compare_q;
	assign res.report_byte   = report_q;
	assign res.report_valid  = rvalid_q;
	assign res.saturated     = sat_q;

	`PFSC_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, !cmd.ready && state_q == ST_SETUP, "command transfer did not start a computation")
	`PFSC_ASSERT_NEXT(a_sweep_hold, clk, arst_n, !(accept && action_t'(cmd.action) == ACT_SWEEP), $stable(sweep_q), "stored frequency changed without a sweep tick")
	`PFSC_ASSERT_IMP(a_div_count, clk, arst_n, state_q == ST_DIV, cnt_q != '0, "division step counter ran out inside the loop")
	`PFSC_ASSERT_NEXT(a_finish_load, clk, arst_n, out_load, res_valid_q && state_q == ST_IDLE, "finished result was not presented")

endmodule
